@@ rtl/core/zrsc_pkg.sv @@
package zrsc_pkg;

  // Default sizes of the codec.
  localparam int VALUE_BITS_DEF  = 64;
  localparam int CHUNK_WIDTH_DEF = 8;

  // Upper bound on the chunks of one encoding; later stream bits are dropped.
  localparam int MAX_RESULTS = 17;

  // Fixed field widths.
  localparam int VALUE_W     = 64;
  localparam int RUN_LIMIT_W = 4;
  localparam int TERM_W      = RUN_LIMIT_W + 1;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register map, indexed by word address.
  localparam logic REG_RUN_LIMIT = 1'b0;

  localparam logic [RUN_LIMIT_W-1:0] RUN_LIMIT_RESET = 4'd2;

  // Result kinds.
  localparam logic KIND_CHUNK = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  // Input actions.
  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

endpackage

@@ rtl/core/zero_run_stuffed_integer_codec.sv @@
// Zero-run limited integer codec.
// Input channel (in_valid/in_stall) carries one transaction per item: with
// action set to encode, value is turned into a bit stream; with action set
// to decode, in_bit is one raw stream bit. Output channel (out_valid/
// out_stall) carries encoded chunks and decoded values from a single output
// register. run_limit is set through the APB port at word address 0.
// Decode: one stream bit per cycle, back to back while the output drains;
// a completed value appears on the output in the cycle after its closing bit.
// Encode: the stream is produced one bit per cycle by a shift register,
// save while a finished chunk waits for the receiver to take the one
// before it. The stream holds the bits up to the highest one, the stuffed
// ones and limit + 1 terminating zeros, where a run_limit of zero counts
// as one. Input is stalled for the whole encoding and while a held result
// waits on a stalled receiver. The first chunk appears once CHUNK_WIDTH
// stream bits are out, or after the whole stream when it is shorter.
// When the receiver stalls a full chunk, bit generation pauses and the
// chunk is held. Reset returns run_limit to 2, clears the decoder state
// and drops any encoding in progress and any undelivered result.
module zero_run_stuffed_integer_codec
  import zrsc_pkg::*;
#(
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [PADDR_W-1:0]                   paddr,
  input  logic [PDATA_W-1:0]                   pwdata,
  output logic [PDATA_W-1:0]                   prdata,
  output logic                                 pready,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [VALUE_W-1:0]                   value,
  input  logic                                 in_bit,
  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 kind,
  output logic [CHUNK_WIDTH-1:0]               chunk_bits,
  output logic [$clog2(CHUNK_WIDTH+1)-1:0]     chunk_count,
  output logic                                 last,
  output logic [VALUE_W-1:0]                   decoded_value,
  output logic                                 overflow
);

  localparam int CNT_W = $clog2(CHUNK_WIDTH + 1);
  localparam int IDX_W = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_TERM
  } state_t;

  state_t                  state;
  logic [RUN_LIMIT_W-1:0]  run_limit;

  // Encoder registers
  logic [VALUE_BITS-1:0]   val_sr;
  logic [RUN_LIMIT_W-1:0]  enc_run;
  logic                    stuff_pend;
  logic [TERM_W-1:0]       term_left;
  logic [CHUNK_WIDTH-1:0]  cbits;
  logic [CNT_W-1:0]        ccnt;
  logic [IDX_W-1:0]        chunk_idx;

  // Decoder registers
  logic [RUN_LIMIT_W-1:0]  zero_run;
  logic [VALUE_BITS-1:0]   accum;
  logic [VALUE_BITS-1:0]   mask;
  logic                    mask_done;
  logic                    overflow_seen;

  logic [RUN_LIMIT_W-1:0]  lim;
  logic                    out_free;
  logic                    in_acc;
  logic                    cfg_wr;
  logic                    enc_bit;
  logic                    enc_final;
  logic                    chunk_full;
  logic                    at_bound;
  logic                    emit_chunk;
  logic                    step;
  logic                    val_nz;
  logic [CHUNK_WIDTH-1:0]  cbits_next;

  // A run limit of zero behaves as one.
  assign lim = (run_limit == '0) ? RUN_LIMIT_W'(1) : run_limit;

  // Handshakes.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RUN_LIMIT) begin
      prdata = PDATA_W'(run_limit);
    end
  end

  // Next stream bit of the encoder and whether it ends the stream.
  assign val_nz = (val_sr != '0);

  always_comb begin
    enc_bit   = 1'b0;
    enc_final = 1'b0;
    case (state)
      ST_DATA: begin
        if (stuff_pend) begin
          enc_bit = 1'b1;
        end else if (val_nz) begin
          enc_bit = val_sr[0];
        end
      end
      ST_TERM: begin
        enc_final = (term_left == TERM_W'(1));
      end
      default: begin
        enc_bit = 1'b0;
      end
    endcase
  end

  assign chunk_full = (ccnt == CNT_W'(CHUNK_WIDTH - 1));
  assign at_bound   = (chunk_idx == IDX_W'(MAX_RESULTS - 1));
  assign emit_chunk = enc_final || chunk_full;
  assign step       = (state != ST_IDLE) && (!emit_chunk || out_free);
  assign cbits_next = cbits | (CHUNK_WIDTH'(enc_bit) << ccnt);

  // Sequencer, codec state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      run_limit     <= RUN_LIMIT_RESET;
      out_valid     <= 1'b0;
      zero_run      <= '0;
      accum         <= '0;
      mask          <= VALUE_BITS'(1);
      mask_done     <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_RUN_LIMIT) begin
        run_limit <= pwdata[RUN_LIMIT_W-1:0];
      end

      // The receiver took the held result.
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      // Start an encoding.
      if (in_acc && action == ACT_ENCODE) begin
        state      <= ST_DATA;
        val_sr     <= value[VALUE_BITS-1:0];
        enc_run    <= '0;
        stuff_pend <= 1'b0;
        cbits      <= '0;
        ccnt       <= '0;
        chunk_idx  <= '0;
      end

      // Decode one stream bit.
      if (in_acc && action == ACT_DECODE) begin
        if (zero_run >= lim) begin
          zero_run <= '0;
          if (!in_bit) begin
            out_valid     <= 1'b1;
            kind          <= KIND_VALUE;
            chunk_bits    <= '0;
            chunk_count   <= '0;
            last          <= 1'b1;
            decoded_value <= VALUE_W'(accum);
            overflow      <= overflow_seen;
            accum         <= '0;
            mask          <= VALUE_BITS'(1);
            mask_done     <= 1'b0;
            overflow_seen <= 1'b0;
          end
        end else begin
          if (in_bit) begin
            zero_run <= '0;
            if (mask_done) begin
              overflow_seen <= 1'b1;
            end else begin
              accum <= accum | mask;
            end
          end else begin
            zero_run <= zero_run + RUN_LIMIT_W'(1);
          end
          if (!mask_done) begin
            mask      <= mask << 1;
            mask_done <= mask[VALUE_BITS-1];
          end
        end
      end

      // Produce one encoded stream bit.
      if (step) begin
        case (state)
          ST_DATA: begin
            if (stuff_pend) begin
              stuff_pend <= 1'b0;
            end else if (val_nz) begin
              val_sr <= val_sr >> 1;
              if (val_sr[0]) begin
                enc_run <= '0;
              end else if (({1'b0, enc_run} + TERM_W'(1)) == {1'b0, lim}) begin
                stuff_pend <= 1'b1;
                enc_run    <= '0;
              end else begin
                enc_run <= enc_run + RUN_LIMIT_W'(1);
              end
            end else begin
              // First terminator zero goes out now; lim more follow.
              state     <= ST_TERM;
              term_left <= {1'b0, lim};
            end
          end
          ST_TERM: begin
            term_left <= term_left - TERM_W'(1);
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase

        if (emit_chunk) begin
          out_valid     <= 1'b1;
          kind          <= KIND_CHUNK;
          chunk_bits    <= cbits_next;
          chunk_count   <= ccnt + CNT_W'(1);
          last          <= enc_final || at_bound;
          decoded_value <= '0;
          overflow      <= 1'b0;
          cbits         <= '0;
          ccnt          <= '0;
          chunk_idx     <= chunk_idx + IDX_W'(1);
          if (enc_final || at_bound) begin
            state <= ST_IDLE;
          end
        end else begin
          cbits <= cbits_next;
          ccnt  <= ccnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

@@ dv/zero_run_stuffed_integer_codec_tb.sv @@
module zero_run_stuffed_integer_codec_tb;
  import zrsc_pkg::*;

  localparam int CHUNK_W       = CHUNK_WIDTH_DEF;
  localparam int CNT_W         = $clog2(CHUNK_W + 1);
  localparam int STREAM_W      = 256;
  localparam int STREAM_MAX    = MAX_RESULTS * CHUNK_W;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int PHASE_ITEMS   = 28;
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic               action;
    logic [VALUE_W-1:0] value;
    logic               in_bit;
  } codec_item_t;

  typedef struct packed {
    logic               kind;
    logic [CHUNK_W-1:0] bits;
    logic [CNT_W-1:0]   count;
    logic               last;
    logic [VALUE_W-1:0] dec_value;
    logic               ovf;
  } codec_result_t;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [VALUE_W-1:0]   value;
  logic                 in_bit;
  logic                 out_valid;
  logic                 out_stall;
  logic                 kind;
  logic [CHUNK_W-1:0]   chunk_bits;
  logic [CNT_W-1:0]     chunk_count;
  logic                 last;
  logic [VALUE_W-1:0]   decoded_value;
  logic                 overflow;

  // Stimulus queue, predicted outputs and the predictor's own copy of the block.
  codec_item_t          codec_in_q[$];
  codec_result_t        codec_out_q[$];
  logic [RUN_LIMIT_W-1:0] limit_reg;
  logic [RUN_LIMIT_W-1:0] stim_limit;
  logic [3:0]           dz_run;
  logic [6:0]           dz_pos;
  logic [VALUE_W-1:0]   dz_accum;
  logic                 dz_ovf;

  logic                 in_taken;
  int                   idle_pct;
  int                   stall_pct;
  int                   items;
  int                   mismatches;
  int unsigned          cycles;

  zero_run_stuffed_integer_codec u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .value        (value),
    .in_bit       (in_bit),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .chunk_bits   (chunk_bits),
    .chunk_count  (chunk_count),
    .last         (last),
    .decoded_value(decoded_value),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A limit of zero behaves as a limit of one.
  function automatic int eff_limit(input logic [RUN_LIMIT_W-1:0] lim);
    return (lim == 0) ? 1 : int'(lim);
  endfunction

  // Raw stream of one value: data bits LSB first up to the top one, a stuffed one
  // after each run of lim zeros, then lim+1 terminating zeros.
  function automatic logic [STREAM_W-1:0] stuffed_stream(input logic [VALUE_W-1:0] val,
                                                          input int lim, output int len);
    logic [STREAM_W-1:0] s;
    logic [VALUE_W-1:0]  v;
    int                  run;
    s   = '0;
    v   = val;
    run = 0;
    len = 0;
    while (v != 0) begin
      s[len] = v[0];
      len++;
      if (v[0]) begin
        run = 0;
      end else begin
        run++;
        if (run == lim) begin
          s[len] = 1'b1;
          len++;
          run = 0;
        end
      end
      v = v >> 1;
    end
    len += lim + 1;
    return s;
  endfunction

  function automatic string fmt_result(input codec_result_t r);
    return $sformatf("kind %0d bits %h count %0d last %0d value %h ovf %0d",
                     r.kind, r.bits, r.count, r.last, r.dec_value, r.ovf);
  endfunction

  // Chunks of one encoding; stream bits beyond the chunk bound are dropped.
  task automatic encode_chunks(input logic [VALUE_W-1:0] val);
    logic [STREAM_W-1:0] s;
    codec_result_t       r;
    int                  len;
    int                  nchunks;
    int                  k;
    s = stuffed_stream(val, eff_limit(limit_reg), len);
    if (len > STREAM_MAX) len = STREAM_MAX;
    nchunks = (len + CHUNK_W - 1) / CHUNK_W;
    for (k = 0; k < nchunks; k++) begin
      r       = '0;
      r.kind  = KIND_CHUNK;
      r.bits  = s[k*CHUNK_W +: CHUNK_W];
      r.count = CNT_W'((len - k*CHUNK_W >= CHUNK_W) ? CHUNK_W : len - k*CHUNK_W);
      r.last  = (k == nchunks - 1);
      codec_out_q.push_back(r);
    end
  endtask

  // One raw bit into the decoder. Once the zero run has reached the limit the
  // bit is a check bit: zero closes the value, one is a stuffed bit.
  task automatic decode_bit(input logic b);
    codec_result_t r;
    if (int'(dz_run) >= eff_limit(limit_reg)) begin
      if (!b) begin
        r           = '0;
        r.kind      = KIND_VALUE;
        r.last      = 1'b1;
        r.dec_value = dz_accum;
        r.ovf       = dz_ovf;
        codec_out_q.push_back(r);
        dz_pos   = '0;
        dz_accum = '0;
        dz_ovf   = 1'b0;
      end
      dz_run = '0;
    end else begin
      if (b) begin
        if (dz_pos < VALUE_BITS_DEF) dz_accum[dz_pos[5:0]] = 1'b1;
        else dz_ovf = 1'b1;
        dz_run = '0;
      end else begin
        dz_run = dz_run + 4'd1;
      end
      if (dz_pos < VALUE_BITS_DEF) dz_pos = dz_pos + 7'd1;
    end
  endtask

  // Prediction on each input transaction and checking of each output transaction.
  always @(posedge clk) begin : monitor_blk
    codec_result_t got;
    codec_result_t want;
    cycles++;
    if (rst) begin
      limit_reg = RUN_LIMIT_RESET;
      dz_run    = '0;
      dz_pos    = '0;
      dz_accum  = '0;
      dz_ovf    = 1'b0;
      in_taken  = 1'b0;
      codec_out_q.delete();
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        if (action == ACT_ENCODE) encode_chunks(value);
        else decode_bit(in_bit);
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_RUN_LIMIT)
        limit_reg = pwdata[RUN_LIMIT_W-1:0];
      if (out_valid && !out_stall) begin
        got = {kind, chunk_bits, chunk_count, last, decoded_value, overflow};
        if (codec_out_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected output transaction: %s", fmt_result(got));
        end else begin
          want = codec_out_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("output mismatch\n  expected %s\n  actual   %s",
                       fmt_result(want), fmt_result(got));
          end
        end
      end
    end
  end

  // Driver: presents queued items at the falling edge, holding each until taken.
  always @(negedge clk) begin : feed_blk
    codec_item_t it;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
      action    <= ACT_ENCODE;
      value     <= '0;
      in_bit    <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
      if (!in_valid || in_taken) begin
        if (codec_in_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          it       = codec_in_q.pop_front();
          in_valid <= 1'b1;
          action   <= it.action;
          value    <= it.value;
          in_bit   <= it.in_bit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic queue_item(input logic act, input logic [VALUE_W-1:0] v, input logic b);
    codec_item_t it;
    it.action = act;
    it.value  = v;
    it.in_bit = b;
    codec_in_q.push_back(it);
    items++;
  endtask

  // Unused fields carry random junk so that the block must ignore them.
  task automatic queue_encode(input logic [VALUE_W-1:0] v);
    queue_item(ACT_ENCODE, v, 1'($urandom_range(1)));
  endtask

  task automatic queue_bit(input logic b);
    queue_item(ACT_DECODE, {$urandom, $urandom}, b);
  endtask

  task automatic queue_stream(input logic [VALUE_W-1:0] v);
    logic [STREAM_W-1:0] s;
    int                  len;
    int                  k;
    s = stuffed_stream(v, eff_limit(stim_limit), len);
    for (k = 0; k < len; k++) queue_bit(s[k]);
  endtask

  // Mostly short values; wide_pct sets the share of full-width ones.
  function automatic logic [VALUE_W-1:0] random_value(input int wide_pct);
    logic [VALUE_W-1:0] v;
    int                 sel;
    v   = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < wide_pct) begin
      case ($urandom_range(2))
        0:       return v;
        1:       return 64'd1 << $urandom_range(63);
        default: return '1;
      endcase
    end
    if (sel < wide_pct + 20)
      return (64'd1 << $urandom_range(23)) | (64'd1 << $urandom_range(23));
    return v & ((64'd1 << $urandom_range(12)) - 64'd1);
  endfunction

  // One random group: an encoding, a clean stream, line noise or a cut-off stream.
  task automatic queue_random_group();
    logic [STREAM_W-1:0] s;
    int                  r;
    int                  n;
    int                  k;
    int                  len;
    r = $urandom_range(99);
    if (r < 30) begin
      queue_encode(random_value(40));
    end else if (r < 85) begin
      queue_stream(random_value(4));
    end else if (r < 95) begin
      n = $urandom_range(6, 1);
      for (k = 0; k < n; k++) queue_bit(1'($urandom_range(1)));
    end else begin
      s = stuffed_stream(random_value(0), eff_limit(stim_limit), len);
      n = $urandom_range(len - 1, 1);
      for (k = 0; k < n; k++) queue_bit(s[k]);
    end
  endtask

  // Waits until every item is taken and every predicted output has arrived.
  task automatic drain();
    @(posedge clk);
    while (codec_in_q.size() != 0 || in_valid || codec_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic set_limit(input logic [RUN_LIMIT_W-1:0] lim);
    logic [PDATA_W-1:0] rd;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_RUN_LIMIT, 2'b00};
    pwdata  <= PDATA_W'(lim);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== PDATA_W'(lim)) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("run_limit read back: expected %h actual %h", PDATA_W'(lim), rd);
    end
    stim_limit = lim;
  endtask

  initial begin : stim_blk
    int p;
    int k;
    int target;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_pct   = 0;
    stall_pct  = 0;
    items      = 0;
    mismatches = 0;
    stim_limit = RUN_LIMIT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit: value extremes, stuffing and an empty value.
    queue_encode('0);
    queue_encode('1);
    queue_encode(64'h8000_0000_0000_0000);
    queue_encode(64'h5);
    queue_stream(64'd6);
    queue_stream(64'b1001);
    queue_stream('0);
    drain();

    // Leave the decoder three zeros into a run, then lower the limit beneath it.
    set_limit(4'd4);
    queue_bit(1'b1);
    queue_bit(1'b0);
    queue_bit(1'b0);
    queue_bit(1'b0);
    drain();
    set_limit(4'd2);
    queue_bit(1'b0);
    drain();

    // Random phases, each with its own limit and idling pattern.
    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin set_limit(4'd1);  idle_pct = 0;  stall_pct = 0;  end
        1: begin set_limit(4'd8);  idle_pct = 85; stall_pct = 0;  end
        2: begin set_limit(4'd0);  idle_pct = 0;  stall_pct = 85; end
        3: begin set_limit(4'd15); idle_pct = 25; stall_pct = 25; end
        default: begin set_limit(4'd5); idle_pct = 0; stall_pct = 0; end
      endcase
      // Ones past the top data bit are dropped and flag an overflow.
      if (p == 0) begin
        for (k = 0; k < VALUE_BITS_DEF + 2; k++) queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b0);
      end
      target = items + PHASE_ITEMS;
      while (items < target) begin
        queue_random_group();
        // Hold the sender back mid-phase until the block has fully emptied.
        if (p == 2 && items >= target - PHASE_ITEMS / 2 && items < target - PHASE_ITEMS / 2 + 8)
          drain();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && codec_out_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hang.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/zrsc_pkg.sv
rtl/core/zero_run_stuffed_integer_codec.sv
dv/zero_run_stuffed_integer_codec_tb.sv
